@@ hw/rtl/bottom_up_merge_sorter_core_macros.svh @@
// Assertion macros for the bottom-up merge sorter RTL.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef BOTTOM_UP_MERGE_SORTER_CORE_MACROS_SVH
`define BOTTOM_UP_MERGE_SORTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BUMS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BUMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/bums_pkg.sv @@
// Shared types and constants for the bottom-up merge sorter.
// No dependencies.
package bums_pkg;

  localparam int VAL_W         = 32;
  localparam int MAX_ITEMS_DEF = 64;

  typedef logic signed [VAL_W-1:0] val_t;

endpackage

@@ hw/rtl/bums_ram.sv @@
// Element memory: one write port, two read ports, registered read data.
// Depends on bums_pkg for the element type.
module bums_ram #(
  parameter int DEPTH = bums_pkg::MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  bums_pkg::val_t      wdata,
  input  logic [AW-1:0]       raddr0,
  input  logic [AW-1:0]       raddr1,
  output bums_pkg::val_t      rdata0_r,
  output bums_pkg::val_t      rdata1_r
);

  bums_pkg::val_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0_r <= mem[raddr0];
    rdata1_r <= mem[raddr1];
  end

endmodule

@@ hw/rtl/bottom_up_merge_sorter_core.sv @@
// Top level of the bottom-up merge sorter: load, ping-pong merge passes, emit.
// Depends on bums_pkg, bums_ram and bottom_up_merge_sorter_core_macros.svh.
//
//   channel | ports                                       | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid, in_stall, in_value, in_last       | to block
//   out     | out_valid, out_stall, out_value_res,        | from block
//           | out_last_res, out_overflowed                |
//
// Load: one transfer per cycle into memory A, items past MAX_ITEMS dropped; in_stall is low only while loading.
// Sort: ceil(log2 n) passes, each merging its run pairs after a setup state per pair;
//   passes alternate A->B and B->A, one merged element written per cycle.
// Emit: an open state primes the read, then one result per cycle while out_stall is low.
// Reset (rst_n, synchronous) clears count, overflow flag, state and out_valid;
//   memories need no clearing, entries are always written before read.
// The output register lets the next set start loading while the final
//   result is still stalled.
`include "bottom_up_merge_sorter_core_macros.svh"

module bottom_up_merge_sorter_core #(
  parameter int MAX_ITEMS = bums_pkg::MAX_ITEMS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    in_value,
  input  logic                  in_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_value_res,
  output logic                  out_last_res,
  output logic                  out_overflowed
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = CW + 2;            // room for lo + 2w before clamping

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_MERGE,
    ST_OPEN,
    ST_EMIT
  } state_t;

  state_t         state_r, state_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           drop_r, drop_nxt;
  logic           pass_r, pass_nxt;      // 0: source A, 1: source B
  logic [PW-1:0]  w_r, w_nxt;
  logic [PW-1:0]  lo_r, lo_nxt;
  logic [PW-1:0]  mid_r, mid_nxt;
  logic [PW-1:0]  hi_r, hi_nxt;
  logic [PW-1:0]  i_r, i_nxt;
  logic [PW-1:0]  j_r, j_nxt;
  logic [PW-1:0]  k_r, k_nxt;
  logic           out_valid_r, out_valid_nxt;
  bums_pkg::val_t out_value_r, out_value_nxt;
  logic           out_last_r, out_last_nxt;
  logic           out_ovf_r, out_ovf_nxt;

  logic           in_xfer;
  logic           out_free;
  logic [PW-1:0]  n_w;
  logic [PW-1:0]  w2;
  logic [PW-1:0]  mid_c, hi_c;
  logic           take_l;
  bums_pkg::val_t src0, src1, merged;

  logic [AW-1:0]  ra0, ra1;
  logic           a_we, b_we;
  logic [AW-1:0]  a_waddr, b_waddr;
  bums_pkg::val_t a_wdata, b_wdata;
  bums_pkg::val_t a_rd0, a_rd1, b_rd0, b_rd1;

  bums_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr0(ra0), .raddr1(ra1), .rdata0_r(a_rd0), .rdata1_r(a_rd1)
  );

  bums_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr0(ra0), .raddr1(ra1), .rdata0_r(b_rd0), .rdata1_r(b_rd1)
  );

  assign in_stall       = (state_r != ST_LOAD);
  assign in_xfer        = in_valid && !in_stall;
  assign out_free       = !out_valid_r || !out_stall;
  assign out_valid      = out_valid_r;
  assign out_value_res  = out_value_r;
  assign out_last_res   = out_last_r;
  assign out_overflowed = out_ovf_r;

  assign n_w   = PW'(cnt_r);
  assign w2    = w_r << 1;
  assign mid_c = ((lo_r + w_r) < n_w) ? (lo_r + w_r) : n_w;
  assign hi_c  = ((lo_r + w2) < n_w) ? (lo_r + w2) : n_w;

  // Read data lines up with i_r / j_r (or k_r while emitting).
  assign src0   = pass_r ? b_rd0 : a_rd0;
  assign src1   = pass_r ? b_rd1 : a_rd1;
  // Stable merge: left run wins ties; right run empty -> take left.
  assign take_l = (i_r < mid_r) && ((j_r >= hi_r) || (src0 <= src1));
  assign merged = take_l ? src0 : src1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    drop_nxt      = drop_r;
    pass_nxt      = pass_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ra0           = i_r[AW-1:0];
    ra1           = j_r[AW-1:0];
    a_we          = 1'b0;
    a_waddr       = k_r[AW-1:0];
    a_wdata       = merged;
    b_we          = 1'b0;
    b_waddr       = k_r[AW-1:0];
    b_wdata       = merged;

    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (cnt_r != CW'(MAX_ITEMS)) begin
            a_we    = 1'b1;
            a_waddr = cnt_r[AW-1:0];
            a_wdata = in_value;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last) begin
            w_nxt    = PW'(1);
            lo_nxt   = '0;
            pass_nxt = 1'b0;
            state_nxt = (cnt_nxt > CW'(1)) ? ST_SETUP : ST_OPEN;
          end
        end
      end

      ST_SETUP: begin
        // Prime reads at the heads of both runs.
        mid_nxt   = mid_c;
        hi_nxt    = hi_c;
        i_nxt     = lo_r;
        j_nxt     = mid_c;
        k_nxt     = lo_r;
        ra0       = lo_r[AW-1:0];
        ra1       = mid_c[AW-1:0];
        state_nxt = ST_MERGE;
      end

      ST_MERGE: begin
        if (pass_r) begin
          a_we = 1'b1;
        end else begin
          b_we = 1'b1;
        end
        k_nxt = k_r + 1'b1;
        if (take_l) begin
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
        ra0 = i_nxt[AW-1:0];
        ra1 = j_nxt[AW-1:0];
        if (k_r == hi_r - 1'b1) begin
          if (hi_r == n_w) begin
            // pass complete: swap memories, double the run width
            w_nxt     = w2;
            pass_nxt  = !pass_r;
            lo_nxt    = '0;
            state_nxt = (w2 >= n_w) ? ST_OPEN : ST_SETUP;
          end else begin
            lo_nxt    = lo_r + w2;
            state_nxt = ST_SETUP;
          end
        end
      end

      ST_OPEN: begin
        k_nxt     = '0;
        ra0       = '0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        ra0 = k_r[AW-1:0];
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = src0;
          out_last_nxt  = (k_r == n_w - 1'b1);
          out_ovf_nxt   = drop_r;
          k_nxt         = k_r + 1'b1;
          ra0           = k_nxt[AW-1:0];
          if (k_r == n_w - 1'b1) begin
            cnt_nxt   = '0;
            drop_nxt  = 1'b0;
            state_nxt = ST_LOAD;
          end
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pass_r      <= pass_nxt;
    w_r         <= w_nxt;
    lo_r        <= lo_nxt;
    mid_r       <= mid_nxt;
    hi_r        <= hi_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  `BUMS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_ITEMS), "item count above capacity")
  `BUMS_ASSERT_NOW(a_run_bound, state_r == ST_MERGE, i_r <= mid_r && j_r <= hi_r, "run overrun")
  `BUMS_ASSERT_NOW(a_out_index, state_r == ST_MERGE, (k_r + mid_r) == (i_r + j_r), "k off heads")
  `BUMS_ASSERT_NEXT(a_emit_done, (state_r == ST_EMIT) && out_free && (k_r == n_w - 1'b1), (state_r == ST_LOAD) && out_last_r, "final result not marked")

endmodule

@@ tb/sort_result_board_pkg.sv @@
`timescale 1ns / 1ps
// Scoreboard for the merge sorter: predicts each sorted set and checks results.
// Depends on bums_pkg for the element type and the store capacity.
package sort_result_board_pkg;
  import bums_pkg::*;

  typedef struct {
    val_t value;
    bit   last;
    bit   ovf;
  } sorted_word_t;

  class sort_result_board;
    localparam int CAP = MAX_ITEMS_DEF;

    val_t         held[CAP];
    val_t         scratch[CAP];
    int           held_count;
    bit           dropped;
    sorted_word_t expected_words[$];
    int           mismatches;

    function new();
      held_count = 0;
      dropped    = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Stable bottom-up merge of runs 1, 2, 4 ... wide; a lone tail run stays put.
    function void sort_held(int n);
      int w, lo, mid, hi, i, j, k;
      for (w = 1; w < n; w = w * 2) begin
        for (lo = 0; lo + w < n; lo = lo + 2 * w) begin
          mid = lo + w;
          hi  = (lo + 2 * w > n) ? n : lo + 2 * w;
          i = lo;
          j = mid;
          k = lo;
          while (i < mid && j < hi) begin
            if (held[i] <= held[j]) begin
              scratch[k] = held[i];
              i++;
            end else begin
              scratch[k] = held[j];
              j++;
            end
            k++;
          end
          while (i < mid) begin
            scratch[k] = held[i];
            i++;
            k++;
          end
          while (j < hi) begin
            scratch[k] = held[j];
            j++;
            k++;
          end
          for (k = lo; k < hi; k++) held[k] = scratch[k];
        end
      end
    endfunction

    // Called for every accepted input transfer.
    function void note_element(val_t v, bit last);
      sorted_word_t w;
      if (held_count < CAP) begin
        held[held_count] = v;
        held_count++;
      end else begin
        dropped = 1;
      end
      if (!last) return;
      sort_held(held_count);
      for (int k = 0; k < held_count; k++) begin
        w.value = held[k];
        w.last  = (k == held_count - 1);
        w.ovf   = dropped;
        expected_words.push_back(w);
      end
      held_count = 0;
      dropped    = 0;
    endfunction

    // Called for every accepted result transfer.
    function void check_element(val_t v, bit last, bit ovf);
      sorted_word_t w;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result value_res=%0d last_res=%0b overflowed=%0b",
                 $time, v, last, ovf);
        return;
      end
      w = expected_words.pop_front();
      if (v !== w.value) begin
        mismatches++;
        $display("%0t: value_res expected %0d got %0d", $time, w.value, v);
      end
      if (last !== w.last) begin
        mismatches++;
        $display("%0t: last_res expected %0b got %0b", $time, w.last, last);
      end
      if (ovf !== w.ovf) begin
        mismatches++;
        $display("%0t: overflowed expected %0b got %0b", $time, w.ovf, ovf);
      end
    endfunction
  endclass
endpackage

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top-level testbench for bottom_up_merge_sorter_core: drives sets, checks sorted output.
// Depends on bums_pkg, sort_result_board_pkg and the sorter RTL.
module tb;
  import bums_pkg::*;
  import sort_result_board_pkg::*;

  localparam val_t VAL_MIN      = 32'sh8000_0000;
  localparam val_t VAL_MAX      = 32'sh7fff_ffff;
  localparam int   RANDOM_ITEMS = 400;
  // Longest quiet stretch of a correct run is a 64-element sort (about six
  // passes) plus a stall; this is several times that.
  localparam int   IDLE_LIMIT   = 4000;
  localparam int   DRAIN_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  val_t in_value;
  logic in_last;
  logic out_valid;
  logic out_stall;
  val_t out_value_res;
  logic out_last_res;
  logic out_overflowed;

  sort_result_board board;
  int  idle_cycles = 0;
  bit  tx_calm;  // sender runs back to back while set
  bit  rx_calm;  // receiver never stalls while set

  bottom_up_merge_sorter_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value_res  (out_value_res),
    .out_last_res   (out_last_res),
    .out_overflowed (out_overflowed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: every transfer on either side goes to the scoreboard; the
  // watchdog counts cycles with no transfer at all.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) board.note_element(in_value, in_last);
      if (out_valid && !out_stall)
        board.check_element(out_value_res, out_last_res, out_overflowed);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: per result, raise stall or not at random, then hold stall low
  // until a transfer happens. Calm stretches keep stall low throughout.
  initial begin
    int k;
    out_stall = 1'b0;
    rx_calm   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 24) == 0) rx_calm = ~rx_calm;
      k = rx_calm ? 0 : $urandom_range(0, 19);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Mostly random words, with extremes and a narrow band around zero so
  // that ties are common.
  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return val_t'($urandom_range(0, 8)) - 4;
      default: return val_t'($urandom);
    endcase
  endfunction

  // One input transfer. Valid is only lowered when a gap is taken, so a
  // back-to-back item never sees valid dropped and raised in one step.
  task automatic send_item(val_t v, bit last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic send_values(val_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(int n);
    for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
  endtask

  // Sender holds off until every expected result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
  endtask

  initial begin
    val_t vals[$];
    int   sent;
    int   n;

    board       = new();
    tx_calm     = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_value    = '0;
    in_last     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: single-element sets at both extremes, a reversed pair,
    // extremes mixed with ties, all-equal, already sorted, reverse sorted.
    vals = {VAL_MIN};
    send_values(vals);
    vals = {VAL_MAX};
    send_values(vals);
    vals = {VAL_MAX, VAL_MIN};
    send_values(vals);
    vals = {val_t'(0), val_t'(-1), VAL_MAX, VAL_MIN, val_t'(-1), val_t'(1), val_t'(0),
            VAL_MIN};
    send_values(vals);
    vals = {val_t'(5), val_t'(5), val_t'(5)};
    send_values(vals);
    vals = {val_t'(1), val_t'(2), val_t'(3), val_t'(4)};
    send_values(vals);
    vals = {val_t'(4), val_t'(3), val_t'(2), val_t'(1), val_t'(0)};
    send_values(vals);
    wait_drained();

    // Exactly full, then two beyond capacity: a plain item and the last
    // item are both dropped, so the whole set comes back flagged.
    send_random_set(MAX_ITEMS_DEF);
    send_random_set(MAX_ITEMS_DEF + 2);
    sent = 2 * MAX_ITEMS_DEF + 2;

    // Random sets, mostly small; the odd one fills or overflows the store.
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) tx_calm = ~tx_calm;
      if ($urandom_range(0, 19) == 0)
        n = MAX_ITEMS_DEF + $urandom_range(0, 4);
      else
        n = $urandom_range(1, 12);
      send_random_set(n);
      sent += n;
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.pending() > 0) begin
      board.mismatches++;
      $display("%0t: %0d expected results never arrived", $time, board.pending());
    end
    if (board.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bums_pkg.sv
hw/rtl/bums_ram.sv
hw/rtl/bottom_up_merge_sorter_core.sv
tb/sort_result_board_pkg.sv
tb/tb.sv
